>>> hw/rtl/mlfq_pkg.sv
`default_nettype none
package mlfq_pkg;
	localparam int Slots = 16;
	localparam int SlotW = 4;
	localparam int LvlW = 2;
	localparam int Levels = 4;

	localparam logic [2:0] CMD_ADD     = 3'd0;
	localparam logic [2:0] CMD_REMOVE  = 3'd1;
	localparam logic [2:0] CMD_SCHED   = 3'd2;
	localparam logic [2:0] CMD_YIELD   = 3'd3;
	localparam logic [2:0] CMD_BLOCK   = 3'd4;
	localparam logic [2:0] CMD_UNBLOCK = 3'd5;
	localparam logic [2:0] CMD_TICK    = 3'd6;
	localparam logic [2:0] CMD_RESCHED = 3'd7;

	localparam logic [2:0] REG_ENABLED = 3'd0;
	localparam logic [2:0] REG_Q0      = 3'd1;
	localparam logic [2:0] REG_Q3      = 3'd4;

	localparam logic [1:0] ST_ABSENT  = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;
	localparam logic [1:0] ST_BLOCKED = 2'd3;

	// follow-up step codes
	localparam logic [1:0] NX_DONE      = 2'd0;
	localparam logic [1:0] NX_SCHED     = 2'd1;
	localparam logic [1:0] NX_INS       = 2'd2;
	localparam logic [1:0] NX_REM_SCHED = 2'd3;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE, OP_DECODE, OP_SCHED_START, OP_SCHED_DEMOTE, OP_SCHED_PICK,
		OP_REM_START, OP_REM_WALK, OP_INS, OP_DONE
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic rem_busy;
		logic [1:0] next_op; // one of the follow-up step codes
		logic demote;
	} stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/mlfq_datapath.sv
`default_nettype none
module mlfq_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire mlfq_pkg::cmd_t cmd_i,
	output mlfq_pkg::stat_t stat_o,
	input  wire logic [2:0] in_cmd,
	input  wire logic [3:0] in_pid,
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_idx,
	input  wire logic [31:0] cfg_dat,
	output logic [3:0] running_id,
	output logic running_valid,
	output logic [1:0] running_level,
	output logic switched,
	output logic [3:0] previous_id,
	output logic resched_pending,
	output logic [7:0] quantum_remaining,
	output logic [31:0] tick_total,
	output logic [31:0] switch_total
);
	import mlfq_pkg::*;

	logic en_q;
	logic [7:0] qreg_q [Levels];
	logic [SlotW-1:0] next_q [Slots];
	logic [LvlW-1:0] lvl_q [Slots];
	logic [1:0] st_q [Slots];
	logic [Slots-1:0] queued_q;
	logic [SlotW-1:0] head_q [Levels];
	logic [Levels-1:0] ne_q;
	logic cv_q;
	logic [SlotW-1:0] cur_q;
	logic [LvlW-1:0] clvl_q;
	logic [7:0] quant_q;
	logic resch_q, sw_q;
	logic [SlotW-1:0] prev_q;
	logic [31:0] tick_q, swc_q;
	// remove walk / pending insert
	logic [SlotW-1:0] rp_q, w_q, ins_p_q;
	logic [LvlW-1:0] ins_l_q;
	logic [SlotW:0] cnt_q;
	logic [1:0] after_q;
	logic busy_q, dem_q;

	logic [LvlW-1:0] fl;
	logic fl_ok;
	always_comb begin
		fl = '0;
		fl_ok = 1'b0;
		for (int i = Levels - 1; i >= 0; i--) begin
			if (ne_q[i]) begin
				fl = LvlW'(i);
				fl_ok = 1'b1;
			end
		end
	end

	assign stat_o.rem_busy = busy_q;
	assign stat_o.next_op = after_q;
	assign stat_o.demote = dem_q;

	logic [SlotW-1:0] pk_h, wn, rl_h, rnext;
	logic [LvlW-1:0] rl;
	assign rl = lvl_q[rp_q];
	assign rl_h = head_q[rl];
	assign rnext = next_q[rp_q];
	assign wn = next_q[w_q];
	assign pk_h = head_q[fl];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			qreg_q[0] <= 8'd5; qreg_q[1] <= 8'd10;
			qreg_q[2] <= 8'd20; qreg_q[3] <= 8'd40;
			for (int i = 0; i < Slots; i++) begin
				lvl_q[i] <= '0;
				st_q[i] <= ST_ABSENT;
			end
			queued_q <= '0;
			for (int i = 0; i < Levels; i++) head_q[i] <= '0;
			ne_q <= '0;
			cv_q <= 1'b0; cur_q <= '0; clvl_q <= '0;
			quant_q <= 8'd5; resch_q <= 1'b0; sw_q <= 1'b0; prev_q <= '0;
			tick_q <= '0; swc_q <= '0;
			busy_q <= 1'b0; after_q <= NX_DONE; dem_q <= 1'b0;
			rp_q <= '0; w_q <= '0; ins_p_q <= '0; ins_l_q <= '0; cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_ENABLED) en_q <= cfg_dat[0];
				else if (cfg_idx >= REG_Q0 && cfg_idx <= REG_Q3)
					qreg_q[2'(cfg_idx - REG_Q0)] <= cfg_dat[7:0];
			end
			case (cmd_i.op)
				OP_DECODE: begin
					sw_q <= 1'b0; prev_q <= '0; after_q <= NX_DONE; dem_q <= 1'b0;
					case (in_cmd)
						CMD_ADD: if (in_pid != '0 && !queued_q[in_pid]) begin
							st_q[in_pid] <= ST_READY;
							ins_p_q <= in_pid; ins_l_q <= '0;
							after_q <= NX_INS; busy_q <= 1'b0;
						end
						CMD_REMOVE: begin
							rp_q <= in_pid; busy_q <= 1'b1; after_q <= NX_DONE;
						end
						CMD_SCHED: after_q <= NX_SCHED;
						CMD_YIELD: if (en_q) begin
							if (cv_q) begin
								st_q[cur_q] <= ST_READY;
								if (ne_q[lvl_q[cur_q]])
									head_q[lvl_q[cur_q]] <= next_q[head_q[lvl_q[cur_q]]];
							end
							quant_q <= '0;
							after_q <= NX_SCHED;
						end
						CMD_BLOCK: if (cv_q) begin
							st_q[cur_q] <= ST_BLOCKED;
							quant_q <= '0;
							rp_q <= cur_q; busy_q <= 1'b1; after_q <= NX_REM_SCHED;
						end
						CMD_UNBLOCK: if (st_q[in_pid] == ST_BLOCKED) begin
							st_q[in_pid] <= ST_READY;
							ins_p_q <= in_pid;
							ins_l_q <= (lvl_q[in_pid] != '0) ? lvl_q[in_pid] - 1'b1 : '0;
							after_q <= NX_INS;
						end
						CMD_TICK: if (en_q) begin
							tick_q <= tick_q + 32'd1;
							if (quant_q <= 8'd1) begin
								quant_q <= '0; resch_q <= 1'b1;
							end else quant_q <= quant_q - 8'd1;
						end
						default: if (resch_q && en_q) begin
							resch_q <= 1'b0;
							if (cv_q && st_q[cur_q] == ST_RUNNING) begin
								st_q[cur_q] <= ST_READY;
								if (ne_q[lvl_q[cur_q]])
									head_q[lvl_q[cur_q]] <= next_q[head_q[lvl_q[cur_q]]];
							end
							after_q <= NX_SCHED;
						end
					endcase
				end
				OP_SCHED_START: begin
					tick_q <= tick_q + 32'd1;
					after_q <= NX_DONE;
					if (fl_ok) begin
						if (quant_q > 8'd1 && cv_q && st_q[cur_q] == ST_RUNNING)
							quant_q <= quant_q - 8'd1;
						else begin
							quant_q <= '0;
							if (cv_q && st_q[cur_q] == ST_RUNNING && quant_q <= 8'd1) begin
								dem_q <= 1'b1;
								st_q[cur_q] <= ST_READY;
								rp_q <= cur_q; busy_q <= 1'b1;
								ins_p_q <= cur_q;
								ins_l_q <= (lvl_q[cur_q] == 2'(Levels - 1)) ?
									lvl_q[cur_q] : lvl_q[cur_q] + 1'b1;
							end else after_q <= NX_SCHED; // go straight to pick
						end
					end
				end
				OP_SCHED_PICK: begin
					dem_q <= 1'b0;
					after_q <= NX_DONE;
					if (fl_ok) begin
						if (!cv_q || pk_h != cur_q) begin
							if (cv_q) begin
								sw_q <= 1'b1; prev_q <= cur_q;
							end
							cv_q <= 1'b1; cur_q <= pk_h; clvl_q <= fl;
							st_q[pk_h] <= ST_RUNNING;
							quant_q <= qreg_q[fl];
							head_q[fl] <= next_q[pk_h];
							swc_q <= swc_q + 32'd1;
						end else quant_q <= qreg_q[lvl_q[cur_q]];
					end
				end
				OP_REM_START: begin
					busy_q <= 1'b0;
					if (queued_q[rp_q]) begin
						queued_q[rp_q] <= 1'b0;
						if (ne_q[rl]) begin
							if (rl_h == rp_q && rnext == rp_q) ne_q[rl] <= 1'b0;
							else begin
								w_q <= rl_h; cnt_q <= '0; busy_q <= 1'b1;
							end
						end
					end
				end
				OP_REM_WALK: if (busy_q) begin
					if (rl_h == rp_q) begin
						if (wn == rl_h || cnt_q == (SlotW+1)'(Slots)) begin
							head_q[rl] <= rnext;
							next_q[w_q] <= rnext;
							busy_q <= 1'b0;
						end else begin
							w_q <= wn; cnt_q <= cnt_q + 1'b1;
						end
					end else begin
						if (wn == rp_q) begin
							next_q[w_q] <= rnext; busy_q <= 1'b0;
						end else if (wn == rl_h || cnt_q == (SlotW+1)'(Slots)) busy_q <= 1'b0;
						else begin
							w_q <= wn; cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				OP_INS: begin
					if (!queued_q[ins_p_q]) begin
						lvl_q[ins_p_q] <= ins_l_q;
						queued_q[ins_p_q] <= 1'b1;
						if (!ne_q[ins_l_q]) begin
							head_q[ins_l_q] <= ins_p_q;
							next_q[ins_p_q] <= ins_p_q;
							ne_q[ins_l_q] <= 1'b1;
						end else begin
							next_q[ins_p_q] <= next_q[head_q[ins_l_q]];
							next_q[head_q[ins_l_q]] <= ins_p_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign running_id = cv_q ? cur_q : '0;
	assign running_valid = cv_q;
	assign running_level = clvl_q;
	assign switched = sw_q;
	assign previous_id = prev_q;
	assign resched_pending = resch_q;
	assign quantum_remaining = quant_q;
	assign tick_total = tick_q;
	assign switch_total = swc_q;
endmodule
`default_nettype wire

>>> hw/rtl/mlfq_ctrl.sv
`default_nettype none
module mlfq_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic out_fire,
	output logic in_busy,
	output logic out_valid,
	output mlfq_pkg::cmd_t cmd_o,
	input  wire mlfq_pkg::stat_t stat_i
);
	import mlfq_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001, S_DEC = 8'b00000010, S_ROUTE = 8'b00000100,
		S_REM = 8'b00001000, S_WALK = 8'b00010000, S_INS = 8'b00100000,
		S_SCHED = 8'b01000000, S_OUT = 8'b10000000
	} state_t;

	state_t state_q;
	logic in_sched_q, pick_q;

	always_comb begin
		case (state_q)
			S_DEC:   cmd_o.op = OP_DECODE;
			S_REM:   cmd_o.op = OP_REM_START;
			S_WALK:  cmd_o.op = OP_REM_WALK;
			S_INS:   cmd_o.op = OP_INS;
			S_SCHED: cmd_o.op = pick_q ? OP_SCHED_PICK : OP_SCHED_START;
			default: cmd_o.op = OP_NONE;
		endcase
	end

	assign in_busy = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; in_sched_q <= 1'b0; pick_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_DEC;
				S_DEC: begin
					in_sched_q <= 1'b0; pick_q <= 1'b0;
					state_q <= S_ROUTE;
				end
				S_ROUTE: begin
					if (stat_i.rem_busy) state_q <= S_REM;
					else if (stat_i.next_op == NX_INS) state_q <= S_INS;
					else if (stat_i.next_op != NX_DONE) begin
						pick_q <= in_sched_q; state_q <= S_SCHED;
					end else state_q <= S_OUT;
				end
				S_REM: state_q <= S_WALK;
				S_WALK: if (!stat_i.rem_busy) begin
					if (stat_i.demote) state_q <= S_INS;
					else if (stat_i.next_op == NX_REM_SCHED) state_q <= S_SCHED;
					else state_q <= S_OUT;
				end
				S_INS: begin
					if (in_sched_q) begin
						pick_q <= 1'b1; state_q <= S_SCHED;
					end else state_q <= S_OUT;
				end
				S_SCHED: begin
					if (pick_q) state_q <= S_OUT;
					else begin
						in_sched_q <= 1'b1;
						state_q <= S_ROUTE;
					end
				end
				S_OUT: if (out_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/mlfq_process_scheduler.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_stall   | cmd, process_id
// out     | output    | valid/stall         | running_id .. switch_total
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
// each event is handled to the end before the next is accepted; a ring removal
// adds a predecessor search over the ring links one slot a cycle; at most
// one removal per event
// reset clears all queues and restores quantum defaults at once
// output held until taken; no new event while a result waits
`default_nettype none
module mlfq_process_scheduler (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [2:0] cmd,
	input  wire logic [3:0] process_id,
	output logic valid,
	input  wire logic stall,
	output logic [3:0] running_id,
	output logic running_valid,
	output logic [1:0] running_level,
	output logic switched,
	output logic [3:0] previous_id,
	output logic resched_pending,
	output logic [7:0] quantum_remaining,
	output logic [31:0] tick_total,
	output logic [31:0] switch_total,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [31:0] cfg_data
);
	import mlfq_pkg::*;

	cmd_t cmd_w;
	stat_t stat_w;
	logic [2:0] cmd_q;
	logic [3:0] pid_q;
	logic in_fire;

	assign in_fire = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= cmd;
			pid_q <= process_id;
		end
	end

	mlfq_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_fire(valid && !stall),
		.in_busy(in_stall), .out_valid(valid), .cmd_o(cmd_w), .stat_i(stat_w)
	);

	mlfq_datapath u_dp (
		.clk, .arst_n, .cmd_i(cmd_w), .stat_o(stat_w),
		.in_cmd(cmd_q), .in_pid(pid_q),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_dat(cfg_data),
		.running_id, .running_valid, .running_level, .switched, .previous_id,
		.resched_pending, .quantum_remaining, .tick_total, .switch_total
	);
endmodule
`default_nettype wire

>>> hw/rtl/mlfq_checker.sv
`default_nettype none
module mlfq_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic valid,
	input wire logic stall,
	input wire logic running_valid,
	input wire logic [3:0] running_id,
	input wire logic switched
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && stall |=> valid) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> in_stall) else $error("input taken while result waits");
	a_sw: assert property (@(posedge clk) disable iff (!arst_n)
		valid && switched |-> running_valid) else $error("switch without process");
	a_id: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !running_valid |-> running_id == 4'd0) else $error("stale id");
endmodule

bind mlfq_process_scheduler mlfq_checker u_chk (
	.clk, .arst_n, .in_stall, .valid, .stall, .running_valid,
	.running_id, .switched
);
`default_nettype wire
